### hdl/sbbf_pkg.sv
`default_nettype none
package sbbf_pkg;

    localparam int LANES        = 8;
    localparam int LANE_W       = 32;
    localparam int POS_W        = $clog2(LANE_W);
    localparam int SEL_SHIFT    = LANE_W - POS_W;
    localparam int BUCKET_W     = LANES * LANE_W;
    localparam int CFG_IDX_W    = $clog2(LANES);

    localparam int IDX_W        = 10;
    localparam int BUCKET_COUNT = 1024;
    // rows above the reach of the index field can never be addressed
    localparam int ROWS         = (BUCKET_COUNT < (1 << IDX_W)) ? BUCKET_COUNT : (1 << IDX_W);
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;

    // reciprocal for index mod ROWS, quotient low by at most one
    localparam int RECIP_SHIFT  = 2 * IDX_W;
    localparam int RECIP_W      = RECIP_SHIFT + 1;
    localparam int RECIP        = (1 << RECIP_SHIFT) / ROWS;

    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int OCC_W        = $clog2(FIFO_DEPTH + 1);

    typedef logic [LANES-1:0][LANE_W-1:0] lane_words_t;

    localparam lane_words_t SALT_RESET = {
        32'd1550580529, 32'd2667345991, 32'd770785867,  32'd1884591559,
        32'd2729259677, 32'd2284105051, 32'd1150766481, 32'd1203114875
    };

    typedef enum logic
    {
        ACT_INSERT = 1'b0,
        ACT_FIND   = 1'b1
    } action_t;

    typedef struct packed
    {
        logic push;
        logic present;
    } result_push_t;

endpackage
`default_nettype wire

### hdl/sbbf_ram.sv
`default_nettype none
module sbbf_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 256
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### hdl/sbbf_lane_mask.sv
`default_nettype none
module sbbf_lane_mask (
    input  wire logic [sbbf_pkg::LANE_W-1:0] hash,
    input  wire sbbf_pkg::lane_words_t       salt,
    output sbbf_pkg::lane_words_t            mask
);

    sbbf_pkg::lane_words_t                           prod;
    logic [sbbf_pkg::LANES-1:0][sbbf_pkg::POS_W-1:0] pos;

    always_comb
    begin
        for (int i = 0; i < sbbf_pkg::LANES; i++)
        begin
            // only the low word of the product is kept
            prod[i] = hash * salt[i];
            // top bits of the low word pick the lane bit
            pos[i]  = prod[i][sbbf_pkg::SEL_SHIFT +: sbbf_pkg::POS_W];
            mask[i] = sbbf_pkg::LANE_W'(1) << pos[i];
        end
    end

endmodule
`default_nettype wire

### hdl/sbbf_out_fifo.sv
`default_nettype none
module sbbf_out_fifo (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sbbf_pkg::result_push_t wr,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic                        out_data
);

    logic [sbbf_pkg::FIFO_DEPTH-1:0] data_reg;
    logic [sbbf_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sbbf_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sbbf_pkg::OCC_W-1:0]      count_reg, count_next;
    logic                            pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr.push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + sbbf_pkg::OCC_W'(wr.push) - sbbf_pkg::OCC_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
        begin
            data_reg[wr_ptr_reg] <= wr.present;
        end
    end

endmodule
`default_nettype wire

### hdl/split_block_bloom_filter_unit.sv
`default_nettype none
// channel | dir | handshake            | fields
// input   | in  | in_valid / in_ready  | action, bucket_index, key_hash
// result  | out | out_valid / out_ready| present
// config  | in  | cfg_we               | cfg_index, cfg_data
//
// one item per cycle sustained while in_ready holds, bounded by the single bucket
// read-modify-write on the directory RAM; results pass stages a and b to the buffer
// after reset a clearing pass zeroes one bucket per cycle (one per addressable
// bucket), with in_ready low; config writes go through
// results queue in a four-entry buffer; in_ready drops while four items are in flight
// back-to-back inserts and finds on one bucket see each other through a forward path
module split_block_bloom_filter_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           action,
    input  wire logic [sbbf_pkg::IDX_W-1:0]     bucket_index,
    input  wire logic [sbbf_pkg::LANE_W-1:0]    key_hash,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                present,
    input  wire logic                           cfg_we,
    input  wire logic [sbbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sbbf_pkg::LANE_W-1:0]    cfg_data
);

    localparam int QP_W = sbbf_pkg::IDX_W + sbbf_pkg::RECIP_W;
    localparam int RP_W = 2 * sbbf_pkg::IDX_W + 1;

    sbbf_pkg::lane_words_t salt_reg, salt_next;

    logic                          clear_busy_reg, clear_busy_next;
    logic [sbbf_pkg::ROW_W-1:0]    clear_row_reg, clear_row_next;
    logic [sbbf_pkg::OCC_W-1:0]    occ_reg, occ_next;

    // stage a: quotient known, row and mask worked out
    logic                          a_valid_reg, a_valid_next;
    logic                          a_act_reg;
    logic [sbbf_pkg::IDX_W-1:0]    a_idx_reg;
    logic [sbbf_pkg::IDX_W-1:0]    a_quot_reg;
    logic [sbbf_pkg::LANE_W-1:0]   a_hash_reg;

    // stage b: bucket data back from the RAM
    logic                          b_valid_reg, b_valid_next;
    logic                          b_act_reg;
    logic [sbbf_pkg::ROW_W-1:0]    b_row_reg;
    logic [sbbf_pkg::BUCKET_W-1:0] b_mask_reg;

    logic                          fwd_valid_reg, fwd_valid_next;
    logic [sbbf_pkg::ROW_W-1:0]    fwd_row_reg;
    logic [sbbf_pkg::BUCKET_W-1:0] fwd_data_reg;

    logic                          in_xfer, out_xfer;
    logic [QP_W-1:0]               quot_prod;
    logic [sbbf_pkg::IDX_W-1:0]    quot;
    logic [RP_W-1:0]               row_prod;
    logic [sbbf_pkg::IDX_W-1:0]    rem_raw, rem;
    logic [sbbf_pkg::ROW_W-1:0]    a_row;
    sbbf_pkg::lane_words_t         a_mask;
    logic [sbbf_pkg::BUCKET_W-1:0] rd_data, bucket, merged;
    logic                          b_insert, hit;
    logic                          ram_we;
    logic [sbbf_pkg::ROW_W-1:0]    ram_waddr;
    logic [sbbf_pkg::BUCKET_W-1:0] ram_wdata;
    sbbf_pkg::result_push_t        res_push;

    assign in_ready = !clear_busy_reg && (occ_reg < sbbf_pkg::OCC_W'(sbbf_pkg::FIFO_DEPTH));
    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // index mod bucket count: reciprocal multiply now, correction next stage
    assign quot_prod = QP_W'(bucket_index) * QP_W'(sbbf_pkg::RECIP);
    assign quot      = quot_prod[sbbf_pkg::RECIP_SHIFT +: sbbf_pkg::IDX_W];

    always_comb
    begin
        row_prod = RP_W'(a_quot_reg) * RP_W'(sbbf_pkg::ROWS);
        rem_raw  = a_idx_reg - row_prod[sbbf_pkg::IDX_W-1:0];
        if ({1'b0, rem_raw} >= (sbbf_pkg::IDX_W+1)'(sbbf_pkg::ROWS))
        begin
            rem = rem_raw - sbbf_pkg::IDX_W'(sbbf_pkg::ROWS);
        end
        else
        begin
            rem = rem_raw;
        end
        a_row = rem[sbbf_pkg::ROW_W-1:0];
    end

    sbbf_lane_mask u_lane_mask (
        .hash (a_hash_reg),
        .salt (salt_reg),
        .mask (a_mask)
    );

    always_comb
    begin
        hit      = fwd_valid_reg && (fwd_row_reg == b_row_reg);
        bucket   = hit ? fwd_data_reg : rd_data;
        merged   = bucket | b_mask_reg;
        b_insert = b_valid_reg && (b_act_reg == sbbf_pkg::ACT_INSERT);

        res_push.push    = b_valid_reg;
        res_push.present = (b_act_reg == sbbf_pkg::ACT_FIND)
                           && ((bucket & b_mask_reg) == b_mask_reg);

        ram_we    = clear_busy_reg || b_insert;
        ram_waddr = clear_busy_reg ? clear_row_reg : b_row_reg;
        ram_wdata = clear_busy_reg ? '0 : merged;

        salt_next = salt_reg;
        if (cfg_we)
        begin
            salt_next[cfg_index] = cfg_data;
        end

        clear_busy_next = clear_busy_reg;
        clear_row_next  = clear_row_reg;
        if (clear_busy_reg)
        begin
            clear_row_next = clear_row_reg + 1'b1;
            if (clear_row_reg == sbbf_pkg::ROW_W'(sbbf_pkg::ROWS - 1))
            begin
                clear_busy_next = 1'b0;
            end
        end

        occ_next       = occ_reg + sbbf_pkg::OCC_W'(in_xfer) - sbbf_pkg::OCC_W'(out_xfer);
        a_valid_next   = in_xfer;
        b_valid_next   = a_valid_reg;
        fwd_valid_next = b_insert;
    end

    sbbf_ram #(
        .DEPTH  (sbbf_pkg::ROWS),
        .ADDR_W (sbbf_pkg::ROW_W),
        .DATA_W (sbbf_pkg::BUCKET_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (a_valid_reg),
        .raddr (a_row),
        .rdata (rd_data)
    );

    sbbf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (res_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (present)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salt_reg       <= sbbf_pkg::SALT_RESET;
            clear_busy_reg <= 1'b1;
            clear_row_reg  <= '0;
            occ_reg        <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            salt_reg       <= salt_next;
            clear_busy_reg <= clear_busy_next;
            clear_row_reg  <= clear_row_next;
            occ_reg        <= occ_next;
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= b_valid_next;
            fwd_valid_reg  <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_act_reg  <= action;
            a_idx_reg  <= bucket_index;
            a_quot_reg <= quot;
            a_hash_reg <= key_hash;
        end
        if (a_valid_reg)
        begin
            b_act_reg  <= a_act_reg;
            b_row_reg  <= a_row;
            b_mask_reg <= a_mask;
        end
        if (b_insert)
        begin
            fwd_row_reg  <= b_row_reg;
            fwd_data_reg <= merged;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= sbbf_pkg::OCC_W'(sbbf_pkg::FIFO_DEPTH))
        else $error("more items in flight than result slots");

    a_stages_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (sbbf_pkg::OCC_W'(a_valid_reg) + sbbf_pkg::OCC_W'(b_valid_reg)) <= occ_reg)
        else $error("pipeline stage holds an item not counted");

    a_no_item_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> (!a_valid_reg && !b_valid_reg && !in_ready))
        else $error("item in flight during clearing pass");

    a_fwd_from_insert: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> ($past(b_valid_reg) && $past(b_act_reg) == sbbf_pkg::ACT_INSERT))
        else $error("forward path armed without an insert");

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import sbbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HISTORY_DEPTH  = 64;
    localparam int HOT_COUNT      = 8;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic                 action       = 1'b0;
    logic [IDX_W-1:0]     bucket_index = '0;
    logic [LANE_W-1:0]    key_hash     = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic                 present;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [LANE_W-1:0]    cfg_data     = '0;

    always #1 clk = ~clk;

    split_block_bloom_filter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .bucket_index (bucket_index),
        .key_hash     (key_hash),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .present      (present),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    typedef struct {
        logic [IDX_W-1:0]  idx;
        logic [LANE_W-1:0] hash;
    } stored_key_t;

    // shadow copy of the filter and its salts
    lane_words_t       salt_model;
    logic [LANE_W-1:0] filter_model [BUCKET_COUNT][LANES];

    logic              pending_present [$];
    stored_key_t       inserted_keys [$];
    logic [IDX_W-1:0]  hot_buckets [HOT_COUNT];
    logic              want_present;

    int errors          = 0;
    int items_sent      = 0;
    int finds_sent      = 0;
    int hits_expected   = 0;
    int results_checked = 0;
    int idle_cycles     = 0;
    int sink_hold       = 0;
    bit src_gaps_on     = 1'b0;
    bit sink_stalls_on  = 1'b0;

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // one insert or find against the shadow filter, returns the expected present bit
    function automatic logic bloom_probe(action_t act, logic [IDX_W-1:0] idx,
                                         logic [LANE_W-1:0] hash);
        logic [LANE_W-1:0] prod;
        logic [LANE_W-1:0] lane_mask;
        logic              all_set;
        all_set = 1'b1;
        for (int i = 0; i < LANES; i++)
        begin
            prod      = hash * salt_model[i];
            lane_mask = 32'd1 << prod[LANE_W-1 -: POS_W];
            if (act == ACT_INSERT)
                filter_model[idx][i] = filter_model[idx][i] | lane_mask;
            else if ((filter_model[idx][i] & lane_mask) != lane_mask)
                all_set = 1'b0;
        end
        return (act == ACT_FIND) && all_set;
    endfunction

    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic lane_words_t random_salts(bit odd_only);
        lane_words_t vals;
        for (int i = 0; i < LANES; i++)
        begin
            vals[i] = $urandom();
            if (odd_only)
                vals[i][0] = 1'b1;
        end
        return vals;
    endfunction

    task automatic send_item(action_t act, logic [IDX_W-1:0] idx, logic [LANE_W-1:0] hash);
        int  gap;
        logic hit;
        gap = pick_gap(src_gaps_on);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        bucket_index <= idx;
        key_hash     <= hash;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        hit = bloom_probe(act, idx, hash);
        pending_present.push_back(hit);
        items_sent++;
        if (act == ACT_FIND)
            finds_sent++;
        if (hit)
            hits_expected++;
    endtask

    // sender holds off until every outstanding result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_present.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_salts(lane_words_t vals, logic [LANES-1:0] which);
        drain_results();
        for (int i = 0; i < LANES; i++)
        begin
            if (which[i])
            begin
                cfg_we    <= 1'b1;
                cfg_index <= CFG_IDX_W'(i);
                cfg_data  <= vals[i];
                @(posedge clk);
                salt_model[i] = vals[i];
            end
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        // finds on a freshly cleared directory
        send_item(ACT_FIND,   10'd0,    32'h0000_0000);
        send_item(ACT_FIND,   10'd1023, 32'hFFFF_FFFF);
        send_item(ACT_INSERT, 10'd0,    32'h0000_0000);
        send_item(ACT_FIND,   10'd0,    32'h0000_0000);
        send_item(ACT_INSERT, 10'd1023, 32'hFFFF_FFFF);
        send_item(ACT_FIND,   10'd1023, 32'hFFFF_FFFF);
        send_item(ACT_FIND,   10'd1023, 32'h0000_0000);
        // insert then find the same bucket on consecutive cycles
        send_item(ACT_INSERT, 10'd1023, 32'h0000_0000);
        send_item(ACT_FIND,   10'd1023, 32'h0000_0000);
        send_item(ACT_FIND,   10'd512,  32'hFFFF_FFFF);
        send_item(ACT_INSERT, 10'h155,  32'hA5A5_A5A5);
        send_item(ACT_FIND,   10'h155,  32'hA5A5_A5A5);
        send_item(ACT_FIND,   10'h2AA,  32'h5A5A_5A5A);
        send_item(ACT_INSERT, 10'h2AA,  32'h5A5A_5A5A);
        send_item(ACT_INSERT, 10'h2AA,  32'h1234_5678);
        send_item(ACT_FIND,   10'h2AA,  32'h5A5A_5A5A);
        send_item(ACT_FIND,   10'h2AA,  32'h1234_5678);
        send_item(ACT_FIND,   10'h2AA,  32'h8765_4321);
        send_item(ACT_FIND,   10'h155,  32'h8000_0000);
        drain_results();
    endtask

    task automatic test_salt_extremes();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        // all-zero salts: every lane selects bit 0
        load_salts('0, '1);
        send_item(ACT_FIND,   10'd7,   32'h0000_007B);
        send_item(ACT_INSERT, 10'd7,   32'hDEAD_BEEF);
        send_item(ACT_FIND,   10'd7,   32'h1234_5678);
        send_item(ACT_FIND,   10'd8,   32'h1234_5678);
        // all-ones salts
        load_salts('1, '1);
        send_item(ACT_INSERT, 10'd300, 32'h0000_0001);
        send_item(ACT_FIND,   10'd300, 32'h0000_0001);
        send_item(ACT_FIND,   10'd300, 32'hFFFF_FFFF);
        send_item(ACT_FIND,   10'd7,   32'h0000_0001);
        // even salts are used as given
        load_salts({32'd1, 32'h8000_0000, 32'd2, 32'd4, 32'hFFFF_FFFE,
                    32'd1, 32'h0800_0000, 32'd6}, '1);
        send_item(ACT_INSERT, 10'd44,  32'h0F0F_0F0F);
        send_item(ACT_FIND,   10'd44,  32'h0F0F_0F0F);
        send_item(ACT_FIND,   10'd44,  32'hF0F0_F0F0);
        send_item(ACT_INSERT, 10'd44,  32'hF0F0_F0F0);
        send_item(ACT_FIND,   10'd44,  32'hF0F0_F0F0);
        load_salts(SALT_RESET, '1);
    endtask

    task automatic run_random_traffic(int count, bit pause_midway);
        int               r;
        stored_key_t      k;
        logic [IDX_W-1:0] idx;
        logic [LANE_W-1:0] hash;
        inserted_keys.delete();
        for (int i = 0; i < HOT_COUNT; i++)
            hot_buckets[i] = IDX_W'($urandom_range(0, BUCKET_COUNT - 1));
        for (int n = 0; n < count; n++)
        begin
            if (pause_midway && n == count / 2)
                drain_results();
            r    = $urandom_range(0, 99);
            idx  = ($urandom_range(0, 9) < 7) ? hot_buckets[$urandom_range(0, HOT_COUNT - 1)]
                                              : IDX_W'($urandom());
            hash = $urandom();
            if (r < 45)
            begin
                send_item(ACT_INSERT, idx, hash);
                k.idx  = idx;
                k.hash = hash;
                inserted_keys.push_back(k);
                if (inserted_keys.size() > HISTORY_DEPTH)
                    void'(inserted_keys.pop_front());
            end
            else if (r < 80 && inserted_keys.size() > 0)
            begin
                k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
                send_item(ACT_FIND, k.idx, k.hash);
            end
            else
                send_item(ACT_FIND, idx, hash);
        end
    endtask

    task automatic test_random_reset_salts();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        run_random_traffic(200, 1'b1);
    endtask

    task automatic test_random_odd_salts();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        load_salts(random_salts(1'b1), '1);
        run_random_traffic(150, 1'b0);
    endtask

    task automatic test_back_to_back();
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        run_random_traffic(60, 1'b0);
        // full rate on the input while the output stalls
        sink_stalls_on = 1'b1;
        run_random_traffic(40, 1'b0);
    endtask

    task automatic test_random_any_salts();
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        load_salts(random_salts(1'b0), '1);
        run_random_traffic(50, 1'b0);
        // rewrite only some lanes
        load_salts(random_salts(1'b0), 8'b1010_0101);
        run_random_traffic(50, 1'b0);
    endtask

    // receiver with random backpressure
    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            out_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else if (sink_stalls_on && $urandom_range(0, 99) < 20)
        begin
            out_ready <= 1'b0;
            sink_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 2);
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_present.size() == 0)
                report_mismatch("result transfer with no item outstanding");
            else
            begin
                want_present = pending_present.pop_front();
                results_checked++;
                if (present !== want_present)
                    report_mismatch($sformatf("present got %b want %b (result %0d)",
                                              present, want_present, results_checked));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int b = 0; b < BUCKET_COUNT; b++)
            for (int i = 0; i < LANES; i++)
                filter_model[b][i] = '0;
        salt_model = SALT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_extremes();
        test_salt_extremes();
        test_random_reset_salts();
        test_random_odd_salts();
        test_back_to_back();
        test_random_any_salts();
        drain_results();

        if (pending_present.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_present.size()));
        $display("covered %0d items (%0d finds, %0d expected hits), %0d results checked",
                 items_sent, finds_sent, hits_expected, results_checked);
        $display("salts: reset, all zero, all ones, even mix, random odd, random and partial");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### sim.f
hdl/sbbf_pkg.sv
hdl/sbbf_ram.sv
hdl/sbbf_lane_mask.sv
hdl/sbbf_out_fifo.sv
hdl/split_block_bloom_filter_unit.sv
tb/tb_top.sv
